>>> rtl/brb_pkg.sv
// Shared types, request and status codes for the byte ring buffer.
`default_nettype none
package brb_pkg;

	localparam int DEPTH_DEF = 256;

	// Request codes
	localparam logic [1:0] REQ_PUT = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_POP = 2'd2;
	localparam logic [1:0] REQ_NOP = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_UNDER = 2'd1;
	localparam logic [1:0] STAT_OVER  = 2'd2;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  width_code;
		logic [63:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [63:0] data_out;
		logic [1:0]  status;
		logic [3:0]  bytes_moved;
		logic [8:0]  fill_count;
	} rsp_t;

	// Control of the byte-serial shift register
	typedef struct packed {
		logic       load;
		logic       shift;
		logic [7:0] byte_in;
	} sh_ctl_t;

	// Bytes moved for a width code: 1, 2, 4 or 8
	function automatic logic [3:0] width_bytes(input logic [1:0] code);
		logic [3:0] n;
		case (code)
			2'd0:    n = 4'd1;
			2'd1:    n = 4'd2;
			2'd2:    n = 4'd4;
			2'd3:    n = 4'd8;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/brb_mem.sv
// Byte store: one write port, one read port with registered read data.
`default_nettype none
module brb_mem #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);
	import brb_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr] & BYTE_MASK;
		end
	end

endmodule
`default_nettype wire

>>> rtl/brb_shreg.sv
// Byte-serial shift register: feeds put bytes out, assembles get bytes in.
`default_nettype none
module brb_shreg (
	input  wire logic             clk,
	input  wire brb_pkg::sh_ctl_t ctl,
	input  wire logic [1:0]       width_code,
	input  wire logic [63:0]      data,
	output logic      [7:0]       top_byte,
	output logic      [63:0]      value
);
	import brb_pkg::*;

	logic [63:0] sh_q;
	logic [63:0] aligned;

	// Left-align the used bytes so the most significant one sits on top
	always_comb begin
		case (width_code)
			2'd0:    aligned = {data[7:0], 56'd0};
			2'd1:    aligned = {data[15:0], 48'd0};
			2'd2:    aligned = {data[31:0], 32'd0};
			2'd3:    aligned = data;
			default: aligned = data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q <= aligned;
		end else if (ctl.shift) begin
			sh_q <= {sh_q[55:0], ctl.byte_in};
		end
	end

	assign top_byte = sh_q[63:56];
	assign value    = sh_q;

endmodule
`default_nettype wire

>>> rtl/byte_ring_buffer_multibyte_unit.sv
// Top level of the multi-byte byte ring buffer with its request sequencer.
`default_nettype none
// A circular store of DEPTH bytes. Issue a transaction by raising start with
// cmd while busy is low; exactly one result transaction follows, shown on rsp
// for a single cycle with done high, and it cannot be held off. A put writes
// 1, 2, 4 or 8 bytes, most significant first; on a full store the remaining
// bytes are dropped and status reports an overrun. A get takes bytes from the
// oldest end and assembles them big-endian; missing bytes read as zero with an
// underrun status. A pop takes the single newest byte. Bytes move one per
// cycle through the byte store and a byte-serial shift register. A put stops
// early when the store fills partway, and the unused request code moves no
// bytes and goes straight to its result. The store needs no clearing after
// reset; the block accepts a transaction right away.
module byte_ring_buffer_multibyte_unit #(
	parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire brb_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output brb_pkg::rsp_t      rsp
);
	import brb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    req_q;
	logic [3:0]    rem_q;
	logic [3:0]    moved_q;
	logic [1:0]    status_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          take_s1;
	logic          hit_s1;

	logic          accept;
	logic          is_read;
	logic          full;
	logic          empty;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [AW-1:0] wp_next;
	logic [AW-1:0] wp_prev;
	logic [AW-1:0] rp_next;
	sh_ctl_t       sh_ctl;
	logic [7:0]    sh_top;
	logic [63:0]   sh_val;
	logic [63:0]   load_data;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign is_read = (req_q == REQ_GET) || (req_q == REQ_POP);
	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);

	// Wrap pointers at DEPTH, which need not be a power of two
	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + AW'(1);
	assign wp_prev = (wp_q == '0) ? PTR_LAST : wp_q - AW'(1);
	assign rp_next = (rp_q == PTR_LAST) ? '0 : rp_q + AW'(1);

	// Only a put loads real data; reads start from a cleared accumulator
	assign load_data = (cmd.req_type == REQ_PUT) ? cmd.data_in : 64'd0;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rp_q;
		if (state_q == ST_RUN) begin
			if (req_q == REQ_PUT) begin
				mem_we = !full;
			end else if (is_read) begin
				mem_re = !empty;
				// Pop reads the newest byte, one slot behind the write pointer
				mem_raddr = (req_q == REQ_POP) ? wp_prev : rp_q;
			end
		end
	end

	// Shift the put byte out as it is written; shift the read byte in on the
	// cycle after, when the store's read data has landed
	always_comb begin
		sh_ctl.load    = accept;
		sh_ctl.shift   = mem_we || take_s1;
		sh_ctl.byte_in = hit_s1 ? mem_rdata : 8'd0;
	end

	brb_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (sh_top),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	brb_shreg u_shreg (
		.clk        (clk),
		.ctl        (sh_ctl),
		.width_code (cmd.width_code),
		.data       (load_data),
		.top_byte   (sh_top),
		.value      (sh_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= REQ_NOP;
			rem_q    <= '0;
			moved_q  <= '0;
			status_q <= STAT_OK;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			take_s1  <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			take_s1 <= 1'b0;
			hit_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q    <= cmd.req_type;
						// Pop always asks for a single byte
						rem_q    <= (cmd.req_type == REQ_POP) ? 4'd1 :
							width_bytes(cmd.width_code);
						moved_q  <= '0;
						status_q <= STAT_OK;
						state_q  <= (cmd.req_type == REQ_NOP) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (req_q == REQ_PUT) begin
						if (full) begin
							// Drop the remaining bytes and report the overrun
							status_q <= STAT_OVER;
							state_q  <= ST_DONE;
						end else begin
							wp_q    <= wp_next;
							cnt_q   <= cnt_q + CW'(1);
							moved_q <= moved_q + 4'd1;
							rem_q   <= rem_q - 4'd1;
							if (rem_q == 4'd1) begin
								state_q <= ST_DONE;
							end
						end
					end else begin
						take_s1 <= 1'b1;
						if (empty) begin
							// Missing bytes read as zero
							status_q <= STAT_UNDER;
						end else begin
							hit_s1  <= 1'b1;
							cnt_q   <= cnt_q - CW'(1);
							moved_q <= moved_q + 4'd1;
							if (req_q == REQ_POP) begin
								wp_q <= wp_prev;
							end else begin
								rp_q <= rp_next;
							end
						end
						rem_q <= rem_q - 4'd1;
						if (rem_q == 4'd1) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// Last read byte shifts in during this cycle
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Present the result for the one cycle spent in the done state
	assign done             = (state_q == ST_DONE);
	assign rsp.data_out     = is_read ? sh_val : 64'd0;
	assign rsp.status       = status_q;
	assign rsp.bytes_moved  = moved_q;
	assign rsp.fill_count   = 9'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("held byte count exceeds depth");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == STAT_OVER) |-> full && (req_q == REQ_PUT))
		else $error("overrun reported while store not full");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == STAT_UNDER) |-> empty && is_read)
		else $error("underrun reported while bytes remain");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule
`default_nettype wire
